// File: design/crld_pkg.sv
// shared types and constants for the cluster run-list decoder
// no dependencies; used by every module of the block
package crld_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SIZE      = 3'd1,
		ST_FULL      = 3'd2,
		ST_AFTER_END = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_RANGE     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		B_IDLE  = 2'd0,
		B_FETCH = 2'd1,
		B_CHECK = 2'd2
	} bstate_t;

	localparam int NIBBLE_MASK  = 'hF;
	localparam int FIELD_BITS   = 32;
	localparam int RESULT_COUNT_W = 7;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  run_byte;
		logic [63:0] cluster_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        list_done;
		logic [32:0] cluster_address;
		logic [6:0]  runs_loaded;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		cmd_t        kind;
		logic [7:0]  run_byte;
		logic [63:0] cluster_index;
	} work_t;

	// sign-extend a little-endian field of nbytes bytes; zero bytes read as 0
	function automatic logic [31:0] sext_field(input logic [31:0] v, input logic [2:0] nbytes);
		logic [31:0] r;
		case (nbytes)
			3'd0: r = '0;
			3'd1: r = {{24{v[7]}}, v[7:0]};
			3'd2: r = {{16{v[15]}}, v[15:0]};
			3'd3: r = {{8{v[23]}}, v[23:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

// File: design/cluster_run_list_decoder.sv
// Cluster run-list decoder. Requests are pushed into a two-entry front queue and results are
// popped from a one-entry result register, so a new request is taken while a result waits.
// A run-list byte, a clear or an unused command is answered straight from the idle state, so a
// byte stream runs at one byte per clock while each result is popped as the next byte is taken.
// A translate query walks the stored runs in order until a hit or the last run; a miss reports a
// range status. The walk reads the run table memory, which has a registered read port, one run
// per cycle. An empty table answers without a walk. A waiting result holds back the next one.
// top level; depends on crld_pkg, crld_front and crld_back
module cluster_run_list_decoder #(
	parameter int MAX_RUNS        = 64,
	parameter int MAX_FIELD_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  crld_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output crld_pkg::out_item_t result
);

	logic            work_valid;
	crld_pkg::work_t work;
	logic            take;
	logic            pop_acc;

	assign pop_acc = pop && !empty;

	crld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.work_valid (work_valid),
		.work       (work),
		.take       (take)
	);

	crld_back #(
		.MAX_RUNS        (MAX_RUNS),
		.MAX_FIELD_BYTES (MAX_FIELD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work       (work),
		.take       (take),
		.empty      (empty),
		.pop        (pop_acc),
		.result     (result)
	);

endmodule

// File: design/crld_front.sv
// front end: two-entry request queue that classifies each accepted item
// depends on crld_pkg
module crld_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  crld_pkg::in_item_t  item,
	output logic                work_valid,
	output crld_pkg::work_t     work,
	input  logic                take
);

	crld_pkg::work_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_take;
	crld_pkg::work_t classified;

	always_comb begin
		classified.run_byte      = item.run_byte;
		classified.cluster_index = item.cluster_index;
		case (item.command)
			crld_pkg::CMD_CLEAR: classified.kind = crld_pkg::CMD_CLEAR;
			crld_pkg::CMD_BYTE:  classified.kind = crld_pkg::CMD_BYTE;
			crld_pkg::CMD_QUERY: classified.kind = crld_pkg::CMD_QUERY;
			default:             classified.kind = crld_pkg::CMD_NONE;
		endcase
	end

	assign full       = (count_q == 2'd2);
	assign work_valid = (count_q != 2'd0);
	assign work       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_take    = take && work_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/crld_back.sv
// back end: run-list parser, run table memory, query walker and result register
// depends on crld_pkg
module crld_back #(
	parameter int MAX_RUNS        = 64,
	parameter int MAX_FIELD_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                work_valid,
	input  crld_pkg::work_t     work,
	output logic                take,
	output logic                empty,
	input  logic                pop,
	output crld_pkg::out_item_t result
);

	localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int CW = $clog2(MAX_RUNS + 1);
	localparam int FW = crld_pkg::FIELD_BITS;
	localparam int RW = crld_pkg::RESULT_COUNT_W;

	// run table: {length, start}
	logic [63:0] table_mem [MAX_RUNS];
	logic [63:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [31:0] rd_len;
	logic [31:0] rd_start;

	crld_pkg::bstate_t state_q, state_d;

	// parser state
	crld_pkg::phase_t phase_q;
	logic [2:0]  len_size_q;
	logic [2:0]  off_size_q;
	logic [2:0]  byte_cnt_q;
	logic [31:0] field_q;
	logic [31:0] pend_len_q;
	logic [31:0] prev_start_q;
	logic [CW-1:0] run_count_q;
	logic        list_ended_q;

	// parser next values
	crld_pkg::phase_t p_phase;
	logic [2:0]  p_len_size;
	logic [2:0]  p_off_size;
	logic [2:0]  p_byte_cnt;
	logic [31:0] p_field;
	logic [31:0] p_pend_len;
	logic [31:0] p_prev_start;
	logic [CW-1:0] p_run_count;
	logic        p_list_ended;
	logic        p_store;
	logic [31:0] p_store_len;
	logic [31:0] p_store_start;
	crld_pkg::status_t p_status;

	// walker
	logic [63:0] idx_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] ptr_inc;
	logic        hit;
	logic        last;

	// result register
	crld_pkg::out_item_t res_q;
	logic        res_valid_q;
	logic        slot_free;

	// control
	logic        res_load;
	crld_pkg::out_item_t res_d;
	logic        par_apply;
	logic        clr;
	logic        q_start;
	logic        q_step;
	logic        mem_we;

	assign rd_len    = rd_data_q[63:32];
	assign rd_start  = rd_data_q[31:0];
	assign ptr_inc   = ptr_q + CW'(1);
	assign hit       = idx_q < {32'd0, rd_len};
	assign last      = (ptr_inc == run_count_q);
	assign slot_free = !res_valid_q || pop;
	// the current entry is read again while the walker waits for the result slot
	assign rd_addr   = q_step ? ptr_inc[AW-1:0] : ptr_q[AW-1:0];
	assign empty     = !res_valid_q;
	assign result    = res_q;

	// one stream byte through the parser
	always_comb begin
		logic [3:0]  ls;
		logic [3:0]  os;
		logic [31:0] fnew;
		logic [2:0]  cnew;
		ls = work.run_byte[3:0];
		os = work.run_byte[7:4];
		fnew = field_q | (FW'(work.run_byte) << {byte_cnt_q[1:0], 3'b000});
		cnew = byte_cnt_q + 3'd1;
		p_phase       = phase_q;
		p_len_size    = len_size_q;
		p_off_size    = off_size_q;
		p_byte_cnt    = byte_cnt_q;
		p_field       = field_q;
		p_pend_len    = pend_len_q;
		p_list_ended  = list_ended_q;
		p_store       = 1'b0;
		p_store_len   = pend_len_q;
		p_store_start = prev_start_q;
		p_status      = crld_pkg::ST_OK;
		if (list_ended_q) begin
			p_status = crld_pkg::ST_AFTER_END;
		end else begin
			case (phase_q)
				crld_pkg::PH_HEADER: begin
					if (work.run_byte == 8'd0) begin
						p_list_ended = 1'b1;
					end else if (ls > 4'(MAX_FIELD_BYTES) || os > 4'(MAX_FIELD_BYTES)) begin
						p_status = crld_pkg::ST_SIZE;
					end else if (run_count_q >= CW'(MAX_RUNS)) begin
						p_status = crld_pkg::ST_FULL;
					end else begin
						p_len_size = ls[2:0];
						p_off_size = os[2:0];
						p_byte_cnt = 3'd0;
						p_field    = '0;
						p_pend_len = '0;
						if (ls == 4'd0) begin
							if (os == 4'd0) begin
								p_store     = 1'b1;
								p_store_len = '0;
								p_phase     = crld_pkg::PH_HEADER;
							end else begin
								p_phase = crld_pkg::PH_OFFSET;
							end
						end else begin
							p_phase = crld_pkg::PH_LENGTH;
						end
					end
				end
				crld_pkg::PH_LENGTH: begin
					if (cnew >= len_size_q) begin
						p_pend_len = fnew;
						p_byte_cnt = 3'd0;
						p_field    = '0;
						if (off_size_q == 3'd0) begin
							p_store     = 1'b1;
							p_store_len = fnew;
							p_phase     = crld_pkg::PH_HEADER;
						end else begin
							p_phase = crld_pkg::PH_OFFSET;
						end
					end else begin
						p_byte_cnt = cnew;
						p_field    = fnew;
					end
				end
				default: begin
					if (cnew >= off_size_q) begin
						p_store       = 1'b1;
						p_store_start = prev_start_q + crld_pkg::sext_field(fnew, off_size_q);
						p_phase       = crld_pkg::PH_HEADER;
						p_byte_cnt    = 3'd0;
						p_field       = '0;
					end else begin
						p_byte_cnt = cnew;
						p_field    = fnew;
					end
				end
			endcase
		end
		p_prev_start = p_store ? p_store_start : prev_start_q;
		p_run_count  = (p_store && run_count_q < CW'(MAX_RUNS)) ? run_count_q + CW'(1)
			: run_count_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			crld_pkg::B_IDLE: begin
				if (work_valid && work.kind == crld_pkg::CMD_QUERY && run_count_q != '0) begin
					state_d = crld_pkg::B_FETCH;
				end
			end
			crld_pkg::B_FETCH: state_d = crld_pkg::B_CHECK;
			crld_pkg::B_CHECK: begin
				if ((hit || last) && slot_free) begin
					state_d = crld_pkg::B_IDLE;
				end
			end
			default: state_d = crld_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		take      = 1'b0;
		res_load  = 1'b0;
		par_apply = 1'b0;
		clr       = 1'b0;
		q_start   = 1'b0;
		q_step    = 1'b0;
		res_d.status          = crld_pkg::ST_OK;
		res_d.list_done       = list_ended_q;
		res_d.cluster_address = '0;
		res_d.runs_loaded     = RW'(run_count_q);
		case (state_q)
			crld_pkg::B_IDLE: begin
				if (work_valid) begin
					case (work.kind)
						crld_pkg::CMD_QUERY: begin
							if (run_count_q == '0) begin
								if (slot_free) begin
									take         = 1'b1;
									res_load     = 1'b1;
									res_d.status = crld_pkg::ST_EMPTY;
								end
							end else begin
								take    = 1'b1;
								q_start = 1'b1;
							end
						end
						crld_pkg::CMD_BYTE: begin
							if (slot_free) begin
								take              = 1'b1;
								res_load          = 1'b1;
								par_apply         = 1'b1;
								res_d.status      = p_status;
								res_d.list_done   = p_list_ended;
								res_d.runs_loaded = RW'(p_run_count);
							end
						end
						crld_pkg::CMD_CLEAR: begin
							if (slot_free) begin
								take              = 1'b1;
								res_load          = 1'b1;
								clr               = 1'b1;
								res_d.list_done   = 1'b0;
								res_d.runs_loaded = '0;
							end
						end
						default: begin
							if (slot_free) begin
								take     = 1'b1;
								res_load = 1'b1;
							end
						end
					endcase
				end
			end
			crld_pkg::B_CHECK: begin
				if (hit) begin
					if (slot_free) begin
						res_load              = 1'b1;
						res_d.cluster_address = {1'b0, rd_start} + {1'b0, idx_q[31:0]};
					end
				end else if (last) begin
					if (slot_free) begin
						res_load     = 1'b1;
						res_d.status = crld_pkg::ST_RANGE;
					end
				end else begin
					q_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign mem_we = par_apply && p_store && (run_count_q < CW'(MAX_RUNS));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[run_count_q[AW-1:0]] <= {p_store_len, p_store_start};
		end
		rd_data_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (q_start) begin
			idx_q <= work.cluster_index;
		end else if (q_step) begin
			idx_q <= idx_q - {32'd0, rd_len};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= crld_pkg::B_IDLE;
			res_valid_q  <= 1'b0;
			ptr_q        <= '0;
			phase_q      <= crld_pkg::PH_HEADER;
			len_size_q   <= '0;
			off_size_q   <= '0;
			byte_cnt_q   <= '0;
			field_q      <= '0;
			pend_len_q   <= '0;
			prev_start_q <= '0;
			run_count_q  <= '0;
			list_ended_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			if (q_start) begin
				ptr_q <= '0;
			end else if (q_step) begin
				ptr_q <= ptr_inc;
			end
			if (clr) begin
				phase_q      <= crld_pkg::PH_HEADER;
				len_size_q   <= '0;
				off_size_q   <= '0;
				byte_cnt_q   <= '0;
				field_q      <= '0;
				pend_len_q   <= '0;
				prev_start_q <= '0;
				run_count_q  <= '0;
				list_ended_q <= 1'b0;
			end else if (par_apply) begin
				phase_q      <= p_phase;
				len_size_q   <= p_len_size;
				off_size_q   <= p_off_size;
				byte_cnt_q   <= p_byte_cnt;
				field_q      <= p_field;
				pend_len_q   <= p_pend_len;
				prev_start_q <= p_prev_start;
				run_count_q  <= p_run_count;
				list_ended_q <= p_list_ended;
			end
		end
	end

endmodule

// File: design/crld_checker.sv
// port-level checks for cluster_run_list_decoder, attached by bind
// depends on crld_pkg
module crld_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input crld_pkg::in_item_t  item,
	input logic                empty,
	input logic                pop,
	input crld_pkg::out_item_t result
);

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != crld_pkg::ST_OK) |-> (result.cluster_address == '0))
		else $error("address set on a failed request");

	a_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == crld_pkg::ST_AFTER_END) |-> result.list_done)
		else $error("byte after end reported without end mark");

	a_empty_tbl: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == crld_pkg::ST_EMPTY) |-> (result.runs_loaded == '0))
		else $error("empty table reported with runs loaded");

endmodule

bind cluster_run_list_decoder crld_checker u_crld_checker (.*);
